@@ sv/sldx_pkg.sv @@
// Package for the sync/length/XOR frame decoder.
// Holds frame layout offsets, register indexes, reset values and the ring command type.
// No dependencies.
package sldx_pkg;

  localparam int OFF_W = 7;

  localparam logic [OFF_W-1:0] SYNC0_OFF     = 7'd0;
  localparam logic [OFF_W-1:0] SYNC1_OFF     = 7'd1;
  localparam logic [OFF_W-1:0] LEN_OFF       = 7'd2;
  localparam logic [OFF_W-1:0] SEQ_OFF       = 7'd3;
  localparam logic [OFF_W-1:0] CMD_OFF       = 7'd4;
  localparam logic [OFF_W-1:0] PAY_OFF       = 7'd5;
  localparam logic [OFF_W-1:0] FRAME_OVH     = 7'd5;
  localparam logic [OFF_W-1:0] MIN_FRAME     = 7'd6;
  localparam logic [OFF_W-1:0] SYNC_BYTES    = 7'd2;
  localparam logic [OFF_W-1:0] ONE_BYTE      = 7'd1;

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_SYNC_FIRST    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SYNC_SECOND   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAYLOAD_LIMIT = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST    = 8'd170;
  localparam logic [7:0] SYNC_SECOND_RST   = 8'd85;
  localparam logic [6:0] PAYLOAD_LIMIT_RST = 7'd32;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [OFF_W-1:0] pop_n;
  } ring_cmd_t;

endpackage

@@ sv/sldx_if.sv @@
// Channel interfaces for the frame decoder: input byte, result and config write.
// Depends on sldx_pkg for the register index width.
interface sldx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sldx_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] frame_seq;
  logic [7:0] frame_cmd;
  logic [6:0] body_len;
  logic       has_byte;
  logic [7:0] payload_byte;
  logic [5:0] byte_index;
  logic       last;
  modport source (output valid, output status, output frame_seq, output frame_cmd,
                  output body_len, output has_byte, output payload_byte,
                  output byte_index, output last, input ready);
  modport sink (input valid, input status, input frame_seq, input frame_cmd,
                input body_len, input has_byte, input payload_byte,
                input byte_index, input last, output ready);
endinterface

interface sldx_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sldx_pkg::REG_IDX_W-1:0] index;
  logic [7:0]                     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/sldx_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sldx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/sldx_ring.sv @@
// Ring pointer unit: head and fill count, tail and offset read address with wrap.
// Depends on sldx_pkg for ring_cmd_t and the offset width.
module sldx_ring #(
  parameter int BUFFER_DEPTH = 512
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sldx_pkg::ring_cmd_t                cmd,
  input  logic [sldx_pkg::OFF_W-1:0]         rd_off,
  output logic [$clog2(BUFFER_DEPTH+1)-1:0]  count,
  output logic [$clog2(BUFFER_DEPTH)-1:0]    wr_addr,
  output logic [$clog2(BUFFER_DEPTH)-1:0]    rd_addr
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int SW = ((CW > sldx_pkg::OFF_W) ? CW : sldx_pkg::OFF_W) + 1;

  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] rd_sum;
  logic [SW-1:0] pop_sum;
  logic [SW-1:0] tail_w;
  logic [SW-1:0] rd_w;
  logic [SW-1:0] pop_w;

  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign rd_sum   = SW'(head_r) + SW'(rd_off);
  assign pop_sum  = SW'(head_r) + SW'(cmd.pop_n);

  assign tail_w = (tail_sum >= SW'(BUFFER_DEPTH)) ? tail_sum - SW'(BUFFER_DEPTH) : tail_sum;
  assign rd_w   = (rd_sum >= SW'(BUFFER_DEPTH)) ? rd_sum - SW'(BUFFER_DEPTH) : rd_sum;
  assign pop_w  = (pop_sum >= SW'(BUFFER_DEPTH)) ? pop_sum - SW'(BUFFER_DEPTH) : pop_sum;

  assign wr_addr = tail_w[AW-1:0];
  assign rd_addr = rd_w[AW-1:0];
  assign count   = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.push) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.pop) begin
      head_r  <= pop_w[AW-1:0];
      count_r <= count_r - CW'(cmd.pop_n);
    end
  end

endmodule

@@ sv/sync_length_xor_frame_decoder.sv @@
// Frame decoder top level: config registers, decode sequencer, ring unit and store.
// Depends on sldx_pkg, sldx_if, sldx_ram and sldx_ring.
// An accepted byte is stored (a full store gives a drop result); then come the sync check
// with one-byte discards on resync, length check, checksum walk and payload results.
// Input ready is high only in idle, so a byte is taken only once the last one is handled.
// Reset clears pointers and count, presets config registers; store contents are not cleared.
module sync_length_xor_frame_decoder #(
  parameter int BUFFER_DEPTH = 512,
  parameter int PAYLOAD_CAP  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  sldx_in_if.sink           in_if,
  sldx_out_if.source        out_if,
  sldx_cfg_if.sink          cfg_if
);

  localparam int AW   = $clog2(BUFFER_DEPTH);
  localparam int CW   = $clog2(BUFFER_DEPTH + 1);
  localparam int CMPW = ((CW > 8) ? CW : 8) + 1;
  localparam int OW   = sldx_pkg::OFF_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DROP, S_SYNC0, S_SYNC1, S_SYNC2, S_LEN, S_LENW,
    S_XOR, S_EMPTY, S_EMIT, S_EMITR
  } state_t;

  state_t              state_r;
  logic [7:0]          sync_first_r;
  logic [7:0]          sync_second_r;
  logic [6:0]          limit_r;
  logic [7:0]          b0_r;
  logic [7:0]          xor_r;
  logic [7:0]          seq_r;
  logic [7:0]          cmd_r;
  logic [OW-1:0]       total_r;
  logic [OW-1:0]       ptr_r;
  logic [6:0]          idx_r;
  logic [6:0]          plen_r;

  logic                out_valid_r;
  logic                out_status_r;
  logic [7:0]          out_seq_r;
  logic [7:0]          out_cmd_r;
  logic [6:0]          out_plen_r;
  logic                out_has_r;
  logic [7:0]          out_byte_r;
  logic [5:0]          out_idx_r;
  logic                out_last_r;

  sldx_pkg::ring_cmd_t ring_cmd;
  logic [OW-1:0]       rd_off;
  logic [CW-1:0]       count;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          rdata;

  logic                acc;
  logic                full;
  logic                out_free;
  logic                out_load;
  logic                sync_hit;
  logic [6:0]          limit_sat;
  logic [7:0]          len_max;
  logic                len_bad;
  logic                cnt_short;
  logic                cnt_lt2;
  logic                cnt_lt6;
  logic                xor_end;
  logic                xor_ok;
  logic                emit_last;
  logic [OW-1:0]       ptr_prev;

  sldx_ring #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ring_cmd),
    .rd_off  (rd_off),
    .count   (count),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr)
  );

  sldx_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_store (
    .clk   (clk),
    .we    (ring_cmd.push),
    .waddr (wr_addr),
    .wdata (in_if.rx_byte),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign acc       = in_if.valid && in_if.ready;
  assign full      = (count == CW'(BUFFER_DEPTH));
  assign out_free  = !out_valid_r || out_if.ready;
  assign out_load  = out_free &&
                     ((state_r == S_DROP) || (state_r == S_EMPTY) || (state_r == S_EMIT));
  assign sync_hit  = (b0_r == sync_first_r) && (rdata == sync_second_r);
  assign limit_sat = (limit_r > 7'(PAYLOAD_CAP)) ? 7'(PAYLOAD_CAP) : limit_r;
  assign len_max   = {1'b0, limit_sat} + 8'd1;
  assign len_bad   = (rdata == 8'd0) || (rdata > len_max);
  assign cnt_short = CMPW'(count) < (CMPW'(rdata) + CMPW'(sldx_pkg::FRAME_OVH));
  assign cnt_lt2   = CMPW'(count) < CMPW'(sldx_pkg::SYNC_BYTES);
  assign cnt_lt6   = CMPW'(count) < CMPW'(sldx_pkg::MIN_FRAME);
  assign xor_end   = (ptr_r == total_r);
  assign xor_ok    = (xor_r == rdata);
  assign emit_last = ((idx_r + 7'd1) == plen_r);
  assign ptr_prev  = ptr_r - OW'(1);

  always_comb begin
    ring_cmd = '0;
    rd_off   = '0;
    case (state_r)
      S_IDLE: begin
        ring_cmd.push = acc && !full;
      end
      S_SYNC0: rd_off = sldx_pkg::SYNC0_OFF;
      S_SYNC1: rd_off = sldx_pkg::SYNC1_OFF;
      S_SYNC2: begin
        ring_cmd.pop   = !sync_hit;
        ring_cmd.pop_n = sldx_pkg::ONE_BYTE;
      end
      S_LEN: rd_off = sldx_pkg::LEN_OFF;
      S_LENW: begin
        rd_off         = sldx_pkg::SEQ_OFF;
        ring_cmd.pop   = len_bad;
        ring_cmd.pop_n = sldx_pkg::ONE_BYTE;
      end
      S_XOR: begin
        if (xor_end) begin
          rd_off         = sldx_pkg::PAY_OFF;
          ring_cmd.pop   = !xor_ok;
          ring_cmd.pop_n = sldx_pkg::ONE_BYTE;
        end else begin
          rd_off = ptr_r;
        end
      end
      S_EMPTY: begin
        ring_cmd.pop   = out_free;
        ring_cmd.pop_n = total_r;
      end
      S_EMIT: begin
        rd_off         = sldx_pkg::PAY_OFF + idx_r;
        ring_cmd.pop   = out_free && emit_last;
        ring_cmd.pop_n = total_r;
      end
      S_EMITR: rd_off = sldx_pkg::PAY_OFF + idx_r;
      default: begin
        ring_cmd = '0;
        rd_off   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= sldx_pkg::SYNC_FIRST_RST;
      sync_second_r <= sldx_pkg::SYNC_SECOND_RST;
      limit_r       <= sldx_pkg::PAYLOAD_LIMIT_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        sldx_pkg::REG_SYNC_FIRST:    sync_first_r  <= cfg_if.data;
        sldx_pkg::REG_SYNC_SECOND:   sync_second_r <= cfg_if.data;
        sldx_pkg::REG_PAYLOAD_LIMIT: limit_r       <= cfg_if.data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            state_r <= full ? S_DROP : S_SYNC0;
          end
        end
        S_DROP: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= 1'b1;
            out_seq_r    <= '0;
            out_cmd_r    <= '0;
            out_plen_r   <= '0;
            out_has_r    <= 1'b0;
            out_byte_r   <= '0;
            out_idx_r    <= '0;
            out_last_r   <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        S_SYNC0: begin
          state_r <= cnt_lt2 ? S_IDLE : S_SYNC1;
        end
        S_SYNC1: begin
          b0_r    <= rdata;
          state_r <= S_SYNC2;
        end
        S_SYNC2: begin
          state_r <= sync_hit ? S_LEN : S_SYNC0;
        end
        S_LEN: begin
          state_r <= cnt_lt6 ? S_IDLE : S_LENW;
        end
        S_LENW: begin
          if (len_bad || cnt_short) begin
            state_r <= S_IDLE;
          end else begin
            total_r <= rdata[OW-1:0] + sldx_pkg::FRAME_OVH;
            plen_r  <= rdata[6:0] - 7'd1;
            xor_r   <= rdata;
            ptr_r   <= sldx_pkg::CMD_OFF;
            state_r <= S_XOR;
          end
        end
        S_XOR: begin
          if (xor_end) begin
            idx_r <= '0;
            if (!xor_ok) begin
              state_r <= S_IDLE;
            end else if (plen_r == 7'd0) begin
              state_r <= S_EMPTY;
            end else begin
              state_r <= S_EMIT;
            end
          end else begin
            xor_r <= xor_r ^ rdata;
            if (ptr_prev == sldx_pkg::SEQ_OFF) begin
              seq_r <= rdata;
            end
            if (ptr_prev == sldx_pkg::CMD_OFF) begin
              cmd_r <= rdata;
            end
            ptr_r <= ptr_r + OW'(1);
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= 1'b0;
            out_seq_r    <= seq_r;
            out_cmd_r    <= cmd_r;
            out_plen_r   <= '0;
            out_has_r    <= 1'b0;
            out_byte_r   <= '0;
            out_idx_r    <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= 1'b0;
            out_seq_r    <= seq_r;
            out_cmd_r    <= cmd_r;
            out_plen_r   <= plen_r;
            out_has_r    <= 1'b1;
            out_byte_r   <= rdata;
            out_idx_r    <= idx_r[5:0];
            out_last_r   <= emit_last;
            if (emit_last) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + 7'd1;
              state_r <= S_EMITR;
            end
          end
        end
        S_EMITR: begin
          state_r <= S_EMIT;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.frame_seq    = out_seq_r;
  assign out_if.frame_cmd    = out_cmd_r;
  assign out_if.body_len     = out_plen_r;
  assign out_if.has_byte     = out_has_r;
  assign out_if.payload_byte = out_byte_r;
  assign out_if.byte_index   = out_idx_r;
  assign out_if.last         = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(BUFFER_DEPTH))
    else $error("fill count beyond store depth");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !full) |=> (count == $past(count) + CW'(1)))
    else $error("accepted byte not added to store");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> full)
    else $error("drop result while store not full");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_XOR) |-> (ptr_r <= total_r))
    else $error("checksum walk ran past frame end");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_status_r && out_has_r && out_last_r)
      |-> ((7'(out_idx_r) + 7'd1) == out_plen_r))
    else $error("last mark not on final payload byte");

endmodule

@@ test/tb_sync_length_xor_frame_decoder.sv @@
// Testbench for sync_length_xor_frame_decoder: drives raw link bytes and register writes,
// predicts the decoded payload words and checks every result word field by field.
// Depends on sldx_pkg, the sldx_if channel interfaces and the decoder RTL.
module tb_sync_length_xor_frame_decoder;

  localparam int DEPTH         = 512;
  localparam int PAYLOAD_CAP   = 32;
  localparam int REST_CYCLES   = 256;
  localparam int QUIET_LIMIT   = 3000;
  localparam int PHASE_BYTES   = 58;

  localparam logic                           STATUS_FRAME = 1'b0;
  localparam logic                           STATUS_DROP  = 1'b1;
  localparam logic [sldx_pkg::REG_IDX_W-1:0] REG_UNUSED   = 2'd3;

  typedef struct packed {
    logic       status;
    logic [7:0] frame_seq;
    logic [7:0] frame_cmd;
    logic [6:0] body_len;
    logic       has_byte;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last;
  } payload_word_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_ONE} row_kind_t;

  typedef struct packed {
    logic [7:0]    b;
    row_kind_t     kind;
    payload_word_t word;
  } script_row_t;

  localparam payload_word_t NO_WORD = '0;
  localparam payload_word_t EMPTY_FRAME_WORD =
    '{STATUS_FRAME, 8'hFF, 8'h00, 7'd0, 1'b0, 8'h00, 6'd0, 1'b1};

  localparam script_row_t OPENING [25] = '{
    '{8'h13, ROW_SILENT, NO_WORD},
    // zero length
    '{8'hAA, ROW_SILENT, NO_WORD}, '{8'h55, ROW_SILENT, NO_WORD},
    '{8'h00, ROW_SILENT, NO_WORD}, '{8'h12, ROW_SILENT, NO_WORD},
    '{8'h34, ROW_SILENT, NO_WORD}, '{8'h56, ROW_SILENT, NO_WORD},
    // length above limit
    '{8'hAA, ROW_SILENT, NO_WORD}, '{8'h55, ROW_SILENT, NO_WORD},
    '{8'h22, ROW_SILENT, NO_WORD}, '{8'h00, ROW_SILENT, NO_WORD},
    '{8'h00, ROW_SILENT, NO_WORD}, '{8'h00, ROW_SILENT, NO_WORD},
    // empty payload
    '{8'hAA, ROW_SILENT, NO_WORD}, '{8'h55, ROW_SILENT, NO_WORD},
    '{8'h01, ROW_SILENT, NO_WORD}, '{8'hFF, ROW_SILENT, NO_WORD},
    '{8'h00, ROW_SILENT, NO_WORD}, '{8'hFE, ROW_ONE, EMPTY_FRAME_WORD},
    // checksum mismatch
    '{8'hAA, ROW_SILENT, NO_WORD}, '{8'h55, ROW_SILENT, NO_WORD},
    '{8'h01, ROW_SILENT, NO_WORD}, '{8'h00, ROW_SILENT, NO_WORD},
    '{8'h00, ROW_SILENT, NO_WORD}, '{8'h00, ROW_SILENT, NO_WORD}
  };

  logic clk = 1'b0;
  logic rst_n;

  sldx_in_if  in_ch();
  sldx_out_if out_ch();
  sldx_cfg_if cfg_ch();

  sync_length_xor_frame_decoder #(
    .BUFFER_DEPTH(DEPTH),
    .PAYLOAD_CAP (PAYLOAD_CAP)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  logic [7:0]    sync_a    = sldx_pkg::SYNC_FIRST_RST;
  logic [7:0]    sync_b    = sldx_pkg::SYNC_SECOND_RST;
  logic [6:0]    limit_reg = sldx_pkg::PAYLOAD_LIMIT_RST;
  logic [7:0]    held_bytes[$];
  payload_word_t pending_words[$];
  logic [7:0]    stim_bytes[$];
  row_kind_t     row_kind;
  payload_word_t row_word;
  bit            calm_in      = 1'b0;
  int            fails        = 0;
  int            quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void decode_byte(input logic [7:0] b);
    int unsigned   lim, len, total, i;
    logic [7:0]    sum;
    payload_word_t w;
    if (held_bytes.size() >= DEPTH) begin
      w = NO_WORD;
      w.status = STATUS_DROP;
      pending_words.insert(pending_words.size(), w);
      return;
    end
    held_bytes.insert(held_bytes.size(), b);
    while (held_bytes.size() >= sldx_pkg::SYNC_BYTES &&
           !(held_bytes[sldx_pkg::SYNC0_OFF] == sync_a &&
             held_bytes[sldx_pkg::SYNC1_OFF] == sync_b))
      void'(held_bytes.pop_front());
    if (held_bytes.size() < sldx_pkg::MIN_FRAME) return;
    lim = (limit_reg > PAYLOAD_CAP) ? PAYLOAD_CAP : limit_reg;
    len = held_bytes[sldx_pkg::LEN_OFF];
    if (len == 0 || len > lim + 1) begin
      void'(held_bytes.pop_front());
      return;
    end
    total = len + sldx_pkg::FRAME_OVH;
    if (held_bytes.size() < total) return;
    sum = '0;
    for (i = sldx_pkg::LEN_OFF; i < total - 1; i++) sum ^= held_bytes[i];
    if (sum != held_bytes[total-1]) begin
      void'(held_bytes.pop_front());
      return;
    end
    w = NO_WORD;
    w.status    = STATUS_FRAME;
    w.frame_seq = held_bytes[sldx_pkg::SEQ_OFF];
    w.frame_cmd = held_bytes[sldx_pkg::CMD_OFF];
    w.body_len  = 7'(len - 1);
    if (len == 1) begin
      w.last = 1'b1;
      pending_words.insert(pending_words.size(), w);
    end else begin
      for (i = 0; i < len - 1; i++) begin
        w.has_byte     = 1'b1;
        w.payload_byte = held_bytes[sldx_pkg::PAY_OFF + i];
        w.byte_index   = 6'(i);
        w.last         = (i == len - 2);
        pending_words.insert(pending_words.size(), w);
      end
    end
    repeat (total) void'(held_bytes.pop_front());
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    payload_word_t want;
    int            base;
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_ch.valid && cfg_ch.ready) begin
        quiet_cycles = 0;
        case (cfg_ch.index)
          sldx_pkg::REG_SYNC_FIRST:    sync_a = cfg_ch.data;
          sldx_pkg::REG_SYNC_SECOND:   sync_b = cfg_ch.data;
          sldx_pkg::REG_PAYLOAD_LIMIT: limit_reg = cfg_ch.data[6:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        quiet_cycles = 0;
        base = pending_words.size();
        decode_byte(in_ch.rx_byte);
        if (row_kind != ROW_PREDICT) begin
          while (pending_words.size() > base) void'(pending_words.pop_back());
          if (row_kind == ROW_ONE) pending_words.insert(pending_words.size(), row_word);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles = 0;
        if (pending_words.size() == 0) begin
          $error("result word arrived with nothing pending");
          fails++;
        end else begin
          want = pending_words.pop_front();
          check_field("status", want.status, out_ch.status);
          check_field("frame_seq", want.frame_seq, out_ch.frame_seq);
          check_field("frame_cmd", want.frame_cmd, out_ch.frame_cmd);
          check_field("body_len", want.body_len, out_ch.body_len);
          check_field("has_byte", want.has_byte, out_ch.has_byte);
          check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
          check_field("byte_index", want.byte_index, out_ch.byte_index);
          check_field("last", want.last, out_ch.last);
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    bit calm_out;
    calm_out = 1'b0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 15) == 0) calm_out = !calm_out;
      stall = calm_out ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  task automatic send_word(input logic [7:0] b, input row_kind_t kind,
                           input payload_word_t word);
    int gap;
    if ($urandom_range(0, 15) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    row_kind      <= kind;
    row_word      <= word;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (REST_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sldx_pkg::REG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic configure(input logic [7:0] first, input logic [7:0] second,
                           input logic [7:0] lim);
    write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
    write_reg(sldx_pkg::REG_SYNC_FIRST, first);
    write_reg(sldx_pkg::REG_SYNC_SECOND, second);
    write_reg(sldx_pkg::REG_PAYLOAD_LIMIT, lim);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic queue_frame(input int len, input bit bad_sum);
    logic [7:0] sum, v;
    stim_bytes.insert(stim_bytes.size(), sync_a);
    stim_bytes.insert(stim_bytes.size(), sync_b);
    stim_bytes.insert(stim_bytes.size(), len[7:0]);
    sum = len[7:0];
    // seq, cmd and len-1 payload bytes
    repeat (len + 1) begin
      v = 8'($urandom_range(0, 255));
      stim_bytes.insert(stim_bytes.size(), v);
      sum ^= v;
    end
    stim_bytes.insert(stim_bytes.size(),
                      bad_sum ? sum ^ (8'd1 << $urandom_range(0, 7)) : sum);
  endtask

  task automatic queue_phase(input int count);
    int pick, top, len;
    top = (limit_reg > PAYLOAD_CAP) ? PAYLOAD_CAP + 1 : limit_reg + 1;
    while (stim_bytes.size() < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len = ($urandom_range(0, 9) == 0) ? top : $urandom_range(1, (top < 6) ? top : 6);
        queue_frame(len, pick >= 70);
      end else if (pick < 88) begin
        len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(top + 1, 255);
        stim_bytes.insert(stim_bytes.size(), sync_a);
        stim_bytes.insert(stim_bytes.size(), sync_b);
        stim_bytes.insert(stim_bytes.size(), len[7:0]);
        repeat ($urandom_range(3, 5))
          stim_bytes.insert(stim_bytes.size(), 8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 4))
          stim_bytes.insert(stim_bytes.size(), 8'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(1, top);
        stim_bytes.insert(stim_bytes.size(), sync_a);
        stim_bytes.insert(stim_bytes.size(), sync_b);
        stim_bytes.insert(stim_bytes.size(), len[7:0]);
        repeat ($urandom_range(0, len))
          stim_bytes.insert(stim_bytes.size(), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] first, input logic [7:0] second,
                           input logic [7:0] lim);
    configure(first, second, lim);
    queue_phase(PHASE_BYTES);
    while (stim_bytes.size() != 0) send_word(stim_bytes.pop_front(), ROW_PREDICT, NO_WORD);
    settle();
  endtask

  initial begin : main
    int i;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= sldx_pkg::REG_SYNC_FIRST;
    cfg_ch.data   <= 8'h00;
    row_kind      <= ROW_PREDICT;
    row_word      <= NO_WORD;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < $size(OPENING); i++)
      send_word(OPENING[i].b, OPENING[i].kind, OPENING[i].word);
    settle();

    run_phase(8'h00, 8'hFF, 8'd0);
    run_phase(8'hFF, 8'h00, 8'hFF);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd1);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd64);
    run_phase(8'hAA, 8'hAA, 8'($urandom_range(1, 32)));

    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
